/* design/sps_pkg.sv */
// Shared types and constants for the single-pattern byte scanner.
// Used by the window cell, the result queue and the top level.
package sps_pkg;

   // Parameter defaults
   localparam int PATTERN_MAX_DEF = 32;
   localparam int OFFSET_BITS_DEF = 32;

   // Fixed field and register widths
   localparam int PAT_BYTES  = 32;
   localparam int LEN_W      = 6;
   localparam int COUNT_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Result queue sizing
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;

   // Full pattern, byte i in bits 8i upward
   typedef logic [PAT_BYTES-1:0][7:0] pattern_type;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH  = 3'd0,
      CSR_PATTERN_BYTES_0 = 3'd1,
      CSR_PATTERN_BYTES_1 = 3'd2,
      CSR_PATTERN_BYTES_2 = 3'd3,
      CSR_PATTERN_BYTES_3 = 3'd4,
      CSR_MATCH_LIMIT     = 3'd5
   } csr_index_type;

   // One result word
   typedef struct packed {
      logic [COUNT_W-1:0] match_offset;
      logic [COUNT_W-1:0] match_total;
      logic               limit_hit;
      logic               is_last;
   } rsp_word_type;

   // Push controls into the result queue
   typedef struct packed {
      logic push_a;
      logic push_b;
   } push_type;

endpackage

/* design/sps_cell.sv */
// One cell of the byte window: holds one recent byte and the pattern byte
// aligned to its place. Depends on sps_pkg.
module sps_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                       clock,
   input  logic                       shift_en,
   input  logic [7:0]                 byte_in,
   input  sps_pkg::pattern_type       pattern,
   input  logic [sps_pkg::LEN_W-1:0]  pat_len,
   output logic [7:0]                 byte_out,
   output logic                       byte_eq
);

   logic [7:0]                data_ff;
   logic [7:0]                pat_ff;
   logic [7:0]                pat_in;
   logic                      act_ff;
   logic                      act_in;
   logic [sps_pkg::LEN_W-1:0] pat_idx;

   // Select the pattern byte that lines up with this cell for the current length
   always_comb begin
      pat_idx = pat_len - sps_pkg::LEN_W'(1) - sps_pkg::LEN_W'(CELL_INDEX);
      pat_in  = pattern[pat_idx[sps_pkg::LEN_W-2:0]];
      act_in  = (pat_len > sps_pkg::LEN_W'(CELL_INDEX));
   end

   // Track the configuration every cycle
   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      act_ff <= act_in;
   end

   // Shift the window byte on each accepted word
   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= byte_in;
      end
   end

   assign byte_out = data_ff;
   assign byte_eq  = !act_ff || (data_ff == pat_ff);

endmodule

/* design/sps_result_queue.sv */
// Result word queue: takes up to two words per cycle, hands out one.
// Depends on sps_pkg.
module sps_result_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  sps_pkg::push_type            push,
   input  sps_pkg::rsp_word_type        word_a,
   input  sps_pkg::rsp_word_type        word_b,
   input  logic                         pop,
   output sps_pkg::rsp_word_type        head,
   output logic [sps_pkg::QCNT_W-1:0]   count
);

   sps_pkg::rsp_word_type             mem [sps_pkg::QUEUE_DEPTH];
   logic [sps_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [sps_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [sps_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [sps_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [sps_pkg::QCNT_W-1:0]        count_ff;
   logic [sps_pkg::QCNT_W-1:0]        count_in;
   logic [sps_pkg::QPTR_W-1:0]        wr_ptr_b;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_b  = wr_ptr_ff + sps_pkg::QPTR_W'(1);
      wr_ptr_in = wr_ptr_ff + sps_pkg::QPTR_W'(push.push_a) + sps_pkg::QPTR_W'(push.push_b);
      rd_ptr_in = rd_ptr_ff + sps_pkg::QPTR_W'(pop);
      count_in  = count_ff + sps_pkg::QCNT_W'(push.push_a) + sps_pkg::QCNT_W'(push.push_b)
                  - sps_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed words in order
   always_ff @(posedge clock) begin
      if (push.push_a) begin
         mem[wr_ptr_ff] <= word_a;
      end
      if (push.push_b) begin
         mem[wr_ptr_b] <= word_b;
      end
   end

   assign head  = mem[rd_ptr_ff];
   assign count = count_ff;

endmodule

/* design/single_pattern_byte_scanner_top.sv */
// Single-pattern byte scanner: one byte per cycle, unless stalled, through a row of window cells.
// Each accepted byte is registered into the window cells and the compare stage; its
// result word is then written into the queue and offered from there.
// Throughput: 1 byte per cycle while results drain; the 8-word result queue
// stalls input once more than 4 words wait (more than 6 with the compare stage idle).
// Reset: synchronous, active high; clears configuration registers, counters and the queue (not the window cells).
module single_pattern_byte_scanner_top #(
   parameter int PATTERN_MAX = sps_pkg::PATTERN_MAX_DEF,
   parameter int OFFSET_BITS = sps_pkg::OFFSET_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // input bytes
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_end_of_buffer,
   // results
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sps_pkg::COUNT_W-1:0]      rsp_match_offset,
   output logic [sps_pkg::COUNT_W-1:0]      rsp_match_total,
   output logic                             rsp_limit_hit,
   output logic                             rsp_is_last,
   // configuration
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sps_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int DIFF_W = (OFFSET_BITS + 1 > sps_pkg::COUNT_W) ? OFFSET_BITS + 1
                                                                : sps_pkg::COUNT_W;

   // Configuration registers
   logic [sps_pkg::LEN_W-1:0]                 len_ff;
   logic [3:0][sps_pkg::CSR_DATA_W-1:0]       pat_regs_ff;
   logic [sps_pkg::COUNT_W-1:0]               limit_ff;
   sps_pkg::pattern_type                      pattern;

   // Input stage
   logic                                      req_accept;
   logic [OFFSET_BITS-1:0]                    pos_ff;
   logic [OFFSET_BITS-1:0]                    pos_in;

   // Compare stage
   logic                                      s1_valid_ff;
   logic                                      s1_last_ff;
   logic [OFFSET_BITS-1:0]                    s1_pos_ff;
   logic [sps_pkg::COUNT_W-1:0]               found_ff;
   logic [sps_pkg::COUNT_W-1:0]               found_in;
   logic                                      stop_ff;
   logic                                      stop_in;

   // Window row
   logic [7:0]                                win_byte [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]                    eq_vec;

   // Compare stage logic
   logic                                      len_ok;
   logic                                      pre_stop;
   logic [DIFF_W-1:0]                         pos_ext;
   logic [DIFF_W-1:0]                         start;
   logic                                      pos_ok;
   logic                                      hit;
   logic [sps_pkg::COUNT_W-1:0]               found_nx;
   logic                                      stop_nx;
   sps_pkg::rsp_word_type                     match_word;
   sps_pkg::rsp_word_type                     close_word;
   sps_pkg::rsp_word_type                     word_a;
   sps_pkg::push_type                         push;

   // Queue side
   sps_pkg::rsp_word_type                     head;
   logic [sps_pkg::QCNT_W-1:0]                q_count;
   logic                                      pop;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         pat_regs_ff <= '0;
         limit_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sps_pkg::CSR_PATTERN_LENGTH:  len_ff         <= csr_data[sps_pkg::LEN_W-1:0];
            sps_pkg::CSR_PATTERN_BYTES_0: pat_regs_ff[0] <= csr_data;
            sps_pkg::CSR_PATTERN_BYTES_1: pat_regs_ff[1] <= csr_data;
            sps_pkg::CSR_PATTERN_BYTES_2: pat_regs_ff[2] <= csr_data;
            sps_pkg::CSR_PATTERN_BYTES_3: pat_regs_ff[3] <= csr_data;
            sps_pkg::CSR_MATCH_LIMIT:     limit_ff       <= csr_data[sps_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign pattern = pat_regs_ff;

   // Hold input while the queue may not fit the results of a new byte and of the one in the compare stage
   assign req_stall  = s1_valid_ff
                       ? (q_count > sps_pkg::QCNT_W'(sps_pkg::QUEUE_DEPTH - 4))
                       : (q_count > sps_pkg::QCNT_W'(sps_pkg::QUEUE_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;

   // Advance byte position, saturating; restart after the buffer's last byte
   always_comb begin
      if (req_end_of_buffer) begin
         pos_in = '0;
      end else if (&pos_ff) begin
         pos_in = pos_ff;
      end else begin
         pos_in = pos_ff + OFFSET_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
         if (req_accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_last_ff <= req_end_of_buffer;
         s1_pos_ff  <= pos_ff;
      end
   end

   // Row of window cells, newest byte in cell 0
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [7:0] cell_in;
      if (k == 0) begin : g_head
         assign cell_in = req_data_byte;
      end else begin : g_body
         assign cell_in = win_byte[k-1];
      end
      sps_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock    (clock),
         .shift_en (req_accept),
         .byte_in  (cell_in),
         .pattern  (pattern),
         .pat_len  (len_ff),
         .byte_out (win_byte[k]),
         .byte_eq  (eq_vec[k])
      );
   end

   // Decide the match and update the per-buffer counters
   always_comb begin
      len_ok   = (len_ff != '0) &&
                 ({1'b0, len_ff} <= (sps_pkg::LEN_W + 1)'(PATTERN_MAX));
      pre_stop = stop_ff || ((found_ff >= limit_ff) && (limit_ff != '0) && (found_ff != '0));
      pos_ext  = DIFF_W'(s1_pos_ff) + DIFF_W'(1);
      start    = pos_ext - DIFF_W'(len_ff);
      pos_ok   = (pos_ext >= DIFF_W'(len_ff));
      hit      = s1_valid_ff && len_ok && (limit_ff != '0) && !pre_stop &&
                 (found_ff < limit_ff) && pos_ok && (&eq_vec);
      found_nx = found_ff + sps_pkg::COUNT_W'(hit);
      stop_nx  = pre_stop || (hit && (found_nx >= limit_ff));

      match_word.match_offset = start[sps_pkg::COUNT_W-1:0];
      match_word.match_total  = found_nx;
      match_word.limit_hit    = stop_nx;
      match_word.is_last      = 1'b0;

      close_word.match_offset = '0;
      close_word.match_total  = found_nx;
      close_word.limit_hit    = stop_nx;
      close_word.is_last      = 1'b1;

      word_a      = hit ? match_word : close_word;
      push.push_a = s1_valid_ff && (hit || s1_last_ff);
      push.push_b = s1_valid_ff && hit && s1_last_ff;

      if (s1_last_ff) begin
         found_in = '0;
         stop_in  = 1'b0;
      end else begin
         found_in = found_nx;
         stop_in  = stop_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= '0;
         stop_ff  <= 1'b0;
      end else if (s1_valid_ff) begin
         found_ff <= found_in;
         stop_ff  <= stop_in;
      end
   end

   // Result words out through the queue
   sps_result_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .word_a (word_a),
      .word_b (close_word),
      .pop    (pop),
      .head   (head),
      .count  (q_count)
   );

   assign rsp_valid        = (q_count != '0);
   assign pop              = rsp_valid && !rsp_stall;
   assign rsp_match_offset = head.match_offset;
   assign rsp_match_total  = head.match_total;
   assign rsp_limit_hit    = head.limit_hit;
   assign rsp_is_last      = head.is_last;

endmodule
